@@ hw/rtl/msalu_pkg.sv @@
// types, codes and constants shared by the masked share unit
// no dependencies; imported by the controller, the datapath and the top level
package msalu_pkg;

    localparam int unsigned SHARE_SLOTS = 8;
    localparam int unsigned RND_BYTES   = 28;

    localparam logic [7:0] LCG_SEED = 8'hAB;
    localparam logic [7:0] LCG_MUL  = 8'h1D;
    localparam logic [7:0] LCG_ADD  = 8'h27;

    typedef enum logic [2:0] {
        ACT_SPLIT     = 3'd0,
        ACT_REFRESH   = 3'd1,
        ACT_XOR       = 3'd2,
        ACT_AND       = 3'd3,
        ACT_RECOMBINE = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        CFG_SHARE_COUNT   = 2'd0,
        CFG_RANDOM_SOURCE = 2'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic needs_steps;
        logic last_step;
    } t_dp_stat;

endpackage

@@ hw/rtl/masked_share_alu.sv @@
// top level of the boolean-masked byte unit: configuration registers,
// share count saturation, controller and datapath; depends on msalu_pkg,
// msalu_ctrl and msalu_dp
//
// usage
//  - input channel i_in_valid / o_in_ready carries one beat per operation:
//    action, plain byte, two share words and four random words
//  - output channel o_out_valid / i_out_ready returns one beat per input beat
//    with the result shares (bytes at or above the share count are zero) and
//    the recombined byte (zero unless recombine)
//  - configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data),
//    written by the user only while the unit is idle, which the unit does not
//    enforce; unknown indexes are ignored
//  - an operation is captured, then takes one step per random byte: split n-1,
//    refresh and and n(n-1)/2, xor, recombine and unknown codes 0; the single
//    random-byte step unit (lcg or word byte) sets that figure
//  - the result passes from S_DONE into the output register as the next beat
//    is taken, in the same cycle; no beat is taken while an operation steps
//  - a stalled receiver keeps the result registered; the unit can accept and
//    work on one further beat, which then waits for the output register
//  - synchronous active-low reset: share count 2, word random source, lcg
//    state 0xab, no result pending; no clearing pass
module masked_share_alu #(
    parameter int unsigned MAX_SHARES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_plain_value,
    input  logic [63:0] i_a_shares,
    input  logic [63:0] i_b_shares,
    input  logic [55:0] i_random_word_0,
    input  logic [55:0] i_random_word_1,
    input  logic [55:0] i_random_word_2,
    input  logic [55:0] i_random_word_3,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_result_shares,
    output logic [7:0]  o_plain_out
);
    import msalu_pkg::*;

    // upper share limit, never beyond the eight byte slots of a share word
    localparam int unsigned MAX_N = (MAX_SHARES > SHARE_SLOTS) ? SHARE_SLOTS :
                                    ((MAX_SHARES < 2) ? 2 : MAX_SHARES);

    logic [3:0] r_share_count;
    logic       r_random_source;
    logic [3:0] w_n;
    logic [2:0] w_n_m1;
    t_dp_cmd    w_cmd;
    t_dp_stat   w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_share_count   <= 4'd2;
            r_random_source <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_SHARE_COUNT:   r_share_count   <= i_cfg_data;
                CFG_RANDOM_SOURCE: r_random_source <= i_cfg_data[0];
                default:           r_share_count   <= r_share_count;
            endcase
        end
    end

    // share count clamped to 2..MAX_N
    always_comb begin
        if (r_share_count < 4'd2) begin
            w_n = 4'd2;
        end else if (r_share_count > 4'(MAX_N)) begin
            w_n = 4'(MAX_N);
        end else begin
            w_n = r_share_count;
        end
    end

    assign w_n_m1 = 3'(w_n - 4'd1);

    msalu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    msalu_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_n_m1          (w_n_m1),
        .i_random_source (r_random_source),
        .i_action        (i_action),
        .i_plain_value   (i_plain_value),
        .i_a_shares      (i_a_shares),
        .i_b_shares      (i_b_shares),
        .i_random_word_0 (i_random_word_0),
        .i_random_word_1 (i_random_word_1),
        .i_random_word_2 (i_random_word_2),
        .i_random_word_3 (i_random_word_3),
        .o_result_shares (o_result_shares),
        .o_plain_out     (o_plain_out)
    );

endmodule

@@ hw/rtl/msalu_ctrl.sv @@
// controller state machine of the masked share unit
// depends on msalu_pkg; drives the datapath through t_dp_cmd
module msalu_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  msalu_pkg::t_dp_stat i_stat,
    output msalu_pkg::t_dp_cmd  o_cmd
);
    import msalu_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;
    logic   w_accept;

    // output register can take a result this cycle
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = i_stat.needs_steps ? S_STEP : S_DONE;
                end
            end
            S_STEP: begin
                if (i_stat.last_step) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_accept) begin
                    n_state = i_stat.needs_steps ? S_STEP : S_DONE;
                end else if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.step     = 1'b0;
        o_cmd.out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
            end
            S_DONE: begin
                o_cmd.out_load = w_out_free;
                o_in_ready     = w_out_free;
                o_cmd.load     = i_in_valid && w_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before it was taken");

    a_last_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP && i_stat.last_step) |=> (r_state == S_DONE))
        else $error("final step did not lead to result stage");

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside result stage");
`endif

endmodule

@@ hw/rtl/msalu_dp.sv @@
// datapath of the masked share unit: operand, share and random registers,
// one random byte per step, output register; depends on msalu_pkg
module msalu_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  msalu_pkg::t_dp_cmd  i_cmd,
    output msalu_pkg::t_dp_stat o_stat,
    input  logic [2:0]          i_n_m1,
    input  logic                i_random_source,
    input  logic [2:0]          i_action,
    input  logic [7:0]          i_plain_value,
    input  logic [63:0]         i_a_shares,
    input  logic [63:0]         i_b_shares,
    input  logic [55:0]         i_random_word_0,
    input  logic [55:0]         i_random_word_1,
    input  logic [55:0]         i_random_word_2,
    input  logic [55:0]         i_random_word_3,
    output logic [63:0]         o_result_shares,
    output logic [7:0]          o_plain_out
);
    import msalu_pkg::*;

    t_action     r_act;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [223:0] r_rnd;
    logic [63:0] r_res;
    logic [7:0]  r_pout;
    logic [63:0] r_out_res;
    logic [7:0]  r_out_plain;
    logic [7:0]  r_prng;
    logic [2:0]  r_i;
    logic [2:0]  r_j;
    logic [4:0]  r_k;

    logic [63:0] w_mask;
    logic [63:0] w_a_m;
    logic [63:0] w_b_m;
    logic [63:0] w_res_init;
    logic [7:0]  w_pout_init;
    logic [15:0] w_prod;
    logic [7:0]  w_lcg;
    logic [7:0]  w_x;
    logic [7:0]  w_cross;
    logic [7:0]  w_t;
    logic [2:0]  w_partner;
    logic [63:0] w_res_step;

    // bytes beyond the share count in use are dropped
    always_comb begin
        for (int l = 0; l < SHARE_SLOTS; l++) begin
            w_mask[8*l +: 8] = (3'(l) <= i_n_m1) ? 8'hFF : 8'h00;
        end
        w_a_m = i_a_shares & w_mask;
        w_b_m = i_b_shares & w_mask;
    end

    always_comb begin
        w_res_init  = '0;
        w_pout_init = '0;
        case (t_action'(i_action))
            ACT_SPLIT: begin
                w_res_init[{i_n_m1, 3'b000} +: 8] = i_plain_value;
            end
            ACT_REFRESH:   w_res_init = w_a_m;
            ACT_XOR:       w_res_init = w_a_m ^ w_b_m;
            ACT_AND:       w_res_init = w_a_m & w_b_m;
            ACT_RECOMBINE: begin
                for (int l = 0; l < SHARE_SLOTS; l++) begin
                    w_pout_init = w_pout_init ^ w_a_m[8*l +: 8];
                end
            end
            default: w_res_init = '0;
        endcase
    end

    assign o_stat.needs_steps =
        t_action'(i_action) inside {ACT_SPLIT, ACT_REFRESH, ACT_AND};

    // split walks shares 0..n-2, pair actions end at pair (n-2, n-1)
    assign o_stat.last_step = (r_act == ACT_SPLIT) ?
        (r_i == i_n_m1 - 3'd1) :
        ((r_i == i_n_m1 - 3'd1) && (r_j == i_n_m1));

    // random byte: next lcg output or the next byte of the captured words
    assign w_prod = 16'(r_prng) * 16'(LCG_MUL);
    assign w_lcg  = w_prod[7:0] + LCG_ADD;
    assign w_x    = i_random_source ? w_lcg : r_rnd[{r_k, 3'b000} +: 8];

    assign w_cross = (r_a[{r_i, 3'b000} +: 8] & r_b[{r_j, 3'b000} +: 8]) ^
                     (r_a[{r_j, 3'b000} +: 8] & r_b[{r_i, 3'b000} +: 8]);
    assign w_partner = (r_act == ACT_SPLIT) ? i_n_m1 : r_j;
    assign w_t       = (r_act == ACT_AND) ? (w_x ^ w_cross) : w_x;

    always_comb begin
        for (int l = 0; l < SHARE_SLOTS; l++) begin
            w_res_step[8*l +: 8] = r_res[8*l +: 8] ^
                ((3'(l) == r_i) ? w_x : 8'h00) ^
                ((3'(l) == w_partner) ? w_t : 8'h00);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act  <= t_action'(i_action);
            r_a    <= w_a_m;
            r_b    <= w_b_m;
            r_rnd  <= {i_random_word_3, i_random_word_2, i_random_word_1, i_random_word_0};
            r_res  <= w_res_init;
            r_pout <= w_pout_init;
        end else if (i_cmd.step) begin
            r_res <= w_res_step;
        end
        if (i_cmd.out_load) begin
            r_out_res   <= r_res;
            r_out_plain <= r_pout;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prng <= LCG_SEED;
            r_i    <= '0;
            r_j    <= 3'd1;
            r_k    <= '0;
        end else if (i_cmd.load) begin
            r_i <= '0;
            r_j <= 3'd1;
            r_k <= '0;
        end else if (i_cmd.step) begin
            r_k <= r_k + 5'd1;
            if (i_random_source) begin
                r_prng <= w_lcg;
            end
            if (r_act == ACT_SPLIT) begin
                r_i <= r_i + 3'd1;
            end else if (r_j == i_n_m1) begin
                r_i <= r_i + 3'd1;
                r_j <= r_i + 3'd2;
            end else begin
                r_j <= r_j + 3'd1;
            end
        end
    end

    assign o_result_shares = r_out_res;
    assign o_plain_out     = r_out_plain;

`ifndef SYNTHESIS
    a_rnd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= 5'(RND_BYTES))
        else $error("random byte index ran past the word supply");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && r_act != ACT_SPLIT) |-> (r_i < r_j))
        else $error("pair counters out of order");

    a_prng_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !i_random_source) |=> $stable(r_prng))
        else $error("lcg advanced while word source selected");
`endif

endmodule
